[src/sorted_unique_key_table_core_defines.svh]
// Assertion helpers shared by the table core. Each expects clk and rst_n in scope.
`ifndef SORTED_UNIQUE_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define SUKT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("table core property violated");

// Next-cycle implication.
`define SUKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("table core property violated");

`endif

[src/sukt_pkg.sv]
`default_nettype none
package sukt_pkg;

  localparam int CAP   = 16;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int IDX_W = $clog2(CAP);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_LISTED   = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_EMPTY,
    OP_LIST
  } op_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] key;
    logic [63:0]        name_w0;
    logic [63:0]        name_w1;
    logic [63:0]        name_w2;
    logic [47:0]        name_w3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] rec_key;
    logic [63:0]        rec_w0;
    logic [63:0]        rec_w1;
    logic [63:0]        rec_w2;
    logic [47:0]        rec_w3;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [47:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } name_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] list_idx;
    logic             list_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage
`default_nettype wire

[src/sukt_ctrl.sv]
`default_nettype none
module sukt_ctrl import sukt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] command,
  input  wire dp_status_t dp_status,
  output dp_cmd_t         dp_cmd,
  output logic            busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             idx_last;

  assign idx_last = (CNT_W'(idx_r) + CNT_W'(1)) == dp_status.count;
  assign busy     = (state_r == S_LIST);

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    dp_cmd.op        = OP_NONE;
    dp_cmd.list_idx  = idx_r;
    dp_cmd.list_last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_INSERT: dp_cmd.op = OP_INSERT;
            CMD_DELETE: dp_cmd.op = OP_DELETE;
            CMD_LIST: begin
              if (dp_status.count == '0) begin
                dp_cmd.op = OP_EMPTY;
              end else begin
                // emit record 0 right away, walk the rest in S_LIST
                dp_cmd.op        = OP_LIST;
                dp_cmd.list_idx  = '0;
                dp_cmd.list_last = (dp_status.count == CNT_W'(1));
                if (dp_status.count != CNT_W'(1)) begin
                  state_nxt = S_LIST;
                  idx_nxt   = IDX_W'(1);
                end
              end
            end
            default: dp_cmd.op = OP_NONE;
          endcase
        end
      end
      S_LIST: begin
        dp_cmd.op        = OP_LIST;
        dp_cmd.list_last = idx_last;
        if (idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

[src/sukt_datapath.sv]
`default_nettype none
`include "sorted_unique_key_table_core_defines.svh"
module sukt_datapath import sukt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  dp_cmd,
  output dp_status_t    dp_status,
  output logic          out_strobe,
  output out_item_t     out_result
);

  logic signed [31:0] slot_key_r  [CAP];
  name_t              slot_name_r [CAP];
  logic [CNT_W-1:0]   count_r;
  out_item_t          out_r;
  logic               out_strobe_r;

  logic [CAP-1:0]     lt, eq, prev_lt;
  logic signed [31:0] up_key [CAP];
  logic signed [31:0] dn_key [CAP];
  name_t              up_name [CAP];
  name_t              dn_name [CAP];
  name_t              new_name;
  logic               dup, full, found;
  logic               do_insert, do_delete;
  logic               list_now, list_more;

  assign new_name = '{w3: in_item.name_w3, w2: in_item.name_w2,
                      w1: in_item.name_w1, w0: in_item.name_w0};

  // per-slot compare cells
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      lt[i] = (count_r > CNT_W'(i)) &&
              ($signed(slot_key_r[i]) < $signed(in_item.key));
      eq[i] = (count_r > CNT_W'(i)) && (slot_key_r[i] == in_item.key);
    end
  end

  assign prev_lt   = {lt[CAP-2:0], 1'b0};
  assign dup       = |eq;
  assign found     = |eq;
  assign full      = (count_r == CNT_W'(CAP));
  assign do_insert = (dp_cmd.op == OP_INSERT) && !dup && !full;
  assign do_delete = (dp_cmd.op == OP_DELETE) && found;

  // neighbor sources for shift up (insert) and shift down (delete)
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      up_key[i]  = in_item.key;
      up_name[i] = new_name;
      dn_key[i]  = slot_key_r[i];
      dn_name[i] = slot_name_r[i];
    end
    for (int i = 1; i < CAP; i++) begin
      up_key[i]  = slot_key_r[i-1];
      up_name[i] = slot_name_r[i-1];
    end
    for (int i = 0; i < CAP - 1; i++) begin
      dn_key[i]  = slot_key_r[i+1];
      dn_name[i] = slot_name_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      if (do_insert && !lt[i]) begin
        slot_key_r[i]  <= prev_lt[i] ? in_item.key : up_key[i];
        slot_name_r[i] <= prev_lt[i] ? new_name : up_name[i];
      end else if (do_delete && !lt[i]) begin
        slot_key_r[i]  <= dn_key[i];
        slot_name_r[i] <= dn_name[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_insert) begin
      count_r <= count_r + CNT_W'(1);
    end else if (do_delete) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (dp_cmd.op != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LIST: begin
        out_r.status  <= ST_LISTED;
        out_r.rec_key <= slot_key_r[dp_cmd.list_idx];
        out_r.rec_w0  <= slot_name_r[dp_cmd.list_idx].w0;
        out_r.rec_w1  <= slot_name_r[dp_cmd.list_idx].w1;
        out_r.rec_w2  <= slot_name_r[dp_cmd.list_idx].w2;
        out_r.rec_w3  <= slot_name_r[dp_cmd.list_idx].w3;
        out_r.last    <= dp_cmd.list_last;
      end
      OP_INSERT, OP_DELETE, OP_EMPTY: begin
        if (dp_cmd.op == OP_EMPTY) begin
          out_r.status <= ST_EMPTY;
        end else if (dp_cmd.op == OP_DELETE) begin
          out_r.status <= found ? ST_DONE : ST_NOTFOUND;
        end else if (dup) begin
          out_r.status <= ST_DUP;
        end else if (full) begin
          out_r.status <= ST_FULL;
        end else begin
          out_r.status <= ST_DONE;
        end
        out_r.rec_key <= in_item.key;
        out_r.rec_w0  <= '0;
        out_r.rec_w1  <= '0;
        out_r.rec_w2  <= '0;
        out_r.rec_w3  <= '0;
        out_r.last    <= 1'b1;
      end
      default: ;
    endcase
  end

  assign dp_status.count = count_r;
  assign out_strobe      = out_strobe_r;
  assign out_result      = out_r;

  assign list_now  = out_strobe_r && (out_r.status == ST_LISTED);
  assign list_more = list_now && !out_r.last;

  `SUKT_ASSERT_NEXT(a_strobe_follows_op, dp_cmd.op != OP_NONE, out_strobe_r)
  `SUKT_ASSERT_NEXT(a_quiet_without_op, dp_cmd.op == OP_NONE, !out_strobe_r)
  `SUKT_ASSERT_NEXT(a_list_ascending, list_more, list_now && (out_r.rec_key > $past(out_r.rec_key)))
  `SUKT_ASSERT_NEXT(a_delete_shrinks, do_delete, count_r == $past(count_r) - CNT_W'(1))
  `SUKT_ASSERT_IMPL(a_insert_has_room, do_insert, count_r < CNT_W'(CAP))

endmodule
`default_nettype wire

[src/sorted_unique_key_table_core.sv]
`default_nettype none
// Sorted unique-key table: up to 16 records kept in ascending signed-key
// order, each with a 30-byte name. Issue a command with start while busy is
// low; it transfers at that edge. Insert and delete update the whole table
// through a row of compare-and-shift slot cells, and their single
// result (done, duplicate, full or not found) appears on the next cycle, so a
// new command may follow every cycle. A list command blocks: busy stays high
// while the controller walks the slots, one record per cycle; results appear
// on consecutive cycles starting the cycle after the transfer, and an empty
// table gives one empty result. The result port cannot be stalled: each
// result shows for exactly one cycle under out_strobe, with last marking the
// final result of a command. Command code 3 is dropped without a result.
module sorted_unique_key_table_core import sukt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_strobe,
  output out_item_t     out_result
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencing: decode commands and step the list walk
  sukt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .command   (in_item.command),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  // storage cells, fill count and result register
  sukt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule
`default_nettype wire
